/* sv/indexed_char_sequence_store_top_defines.svh */
// assertion macros shared by the sequence store rtl
// expects clk and arst_n in the scope of each use
`ifndef INDEXED_CHAR_SEQUENCE_STORE_TOP_DEFINES_SVH
`define INDEXED_CHAR_SEQUENCE_STORE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define ICS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ICS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICS_ASSERT(name, prop, msg)
`define ICS_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* sv/icss_pkg.sv */
// types, codes and command decode for the indexed character sequence store
// used by the controller, datapath and top level
package icss_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef enum logic [3:0] {
		CMD_PUSH_FRONT    = 4'd0,
		CMD_PUSH_BACK     = 4'd1,
		CMD_INSERT_AT     = 4'd2,
		CMD_INSERT_SORTED = 4'd3,
		CMD_REMOVE_AT     = 4'd4,
		CMD_POP_FRONT     = 4'd5,
		CMD_POP_BACK      = 4'd6,
		CMD_REPLACE_AT    = 4'd7,
		CMD_READ_AT       = 4'd8,
		CMD_FIRST         = 4'd9,
		CMD_LAST          = 4'd10,
		CMD_FIND          = 4'd11,
		CMD_SIZE          = 4'd12,
		CMD_CLEAR         = 4'd13
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// what kind of work a command needs
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS,
		OP_SORT,
		OP_FIND,
		OP_REM,
		OP_REPL,
		OP_READ,
		OP_CLEAR
	} opcls_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_PREP,
		S_SHIFT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic prep;
		logic shift;
		logic finish;
	} ctl_t;

	typedef struct packed {
		opcls_t cls;
		logic   err;
		logic   rem_zero;
		logic   pend;
		logic   hit;
	} sts_t;

	function automatic opcls_t cmd_class(input logic [3:0] cmd);
		opcls_t c;
		case (cmd) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: c = OP_INS;
			CMD_INSERT_SORTED: c = OP_SORT;
			CMD_FIND: c = OP_FIND;
			CMD_REMOVE_AT, CMD_POP_FRONT, CMD_POP_BACK: c = OP_REM;
			CMD_REPLACE_AT: c = OP_REPL;
			CMD_READ_AT, CMD_FIRST, CMD_LAST: c = OP_READ;
			CMD_CLEAR: c = OP_CLEAR;
			default: c = OP_NONE;
		endcase
		return c;
	endfunction

endpackage

/* sv/icss_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
module icss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/icss_dpath.sv */
// datapath of the sequence store: command registers, element ram, count,
// scan and shift pointers, result registers; needs icss_pkg and icss_ram
`include "indexed_char_sequence_store_top_defines.svh"
module icss_dpath #(
	parameter int CAPACITY = icss_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         command,
	input  logic signed [7:0]  element,
	input  logic [6:0]         index,
	input  icss_pkg::ctl_t     ctl,
	output icss_pkg::sts_t     sts,
	output logic signed [7:0]  data,
	output logic               found,
	output logic [6:0]         length,
	output logic [1:0]         status
);
	import icss_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [3:0]        cmd_q;
	logic signed [7:0] elem_q;
	logic [6:0]        idx_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_q;
	logic [CW-1:0]     rem_q;
	logic              pend_q;
	logic [AW-1:0]     wa_q;
	logic [CW-1:0]     pos_q;
	logic              hit_q;
	logic signed [7:0] data_q;
	logic              found_q;
	logic [6:0]        length_q;
	logic [1:0]        status_q;

	opcls_t            cls;
	status_t           st_c;
	logic              err;
	logic              full;
	logic              empty;
	logic              up;
	logic              rem_zero;
	logic              hit_c;
	logic [XW-1:0]     idx_x;
	logic [XW-1:0]     cnt_x;
	logic [CW-1:0]     tgt_c;
	logic [CW-1:0]     cnt_new;
	logic [XW-1:0]     cnt_new_x;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic signed [7:0] rdata;

	assign cls      = cmd_class(cmd_q);
	assign idx_x    = XW'(idx_q);
	assign cnt_x    = XW'(count_q);
	assign full     = count_q == CAP_C;
	assign empty    = count_q == '0;
	assign up       = (cls == OP_INS) || (cls == OP_SORT);
	assign rem_zero = rem_q == '0;
	assign err      = st_c != ST_OK;

	// find matches bytes, sorted insert stops at the first greater element
	assign hit_c = pend_q && ((cls == OP_FIND) ? (rdata == elem_q) : (rdata > elem_q));

	always_comb begin
		st_c = ST_OK;
		case (cmd_q) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_SORTED: begin
				if (full) st_c = ST_FULL;
			end
			CMD_INSERT_AT: begin
				if (idx_x > cnt_x) st_c = ST_RANGE;
				else if (full) st_c = ST_FULL;
			end
			CMD_REMOVE_AT, CMD_REPLACE_AT, CMD_READ_AT: begin
				if (idx_x >= cnt_x) st_c = ST_RANGE;
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_FIRST, CMD_LAST: begin
				if (empty) st_c = ST_EMPTY;
			end
			default: st_c = ST_OK;
		endcase
	end

	// position the command works on
	always_comb begin
		case (cmd_q) inside
			CMD_PUSH_BACK, CMD_INSERT_SORTED: tgt_c = count_q;
			CMD_INSERT_AT, CMD_REMOVE_AT, CMD_REPLACE_AT, CMD_READ_AT: tgt_c = idx_x[CW-1:0];
			CMD_POP_BACK, CMD_LAST: tgt_c = count_q - 1'b1;
			default: tgt_c = '0;
		endcase
	end

	always_comb begin
		cnt_new = count_q;
		if (!err) begin
			case (cls)
				OP_INS, OP_SORT: cnt_new = count_q + 1'b1;
				OP_REM: cnt_new = count_q - 1'b1;
				OP_CLEAR: cnt_new = '0;
				default: cnt_new = count_q;
			endcase
		end
	end

	assign cnt_new_x = XW'(cnt_new);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = rdata;
		if (ctl.exec && cls == OP_READ) begin
			ram_re    = 1'b1;
			ram_raddr = tgt_c[AW-1:0];
		end
		if (ctl.exec && cls == OP_REPL && !err) begin
			ram_we    = 1'b1;
			ram_waddr = tgt_c[AW-1:0];
			ram_wdata = elem_q;
		end
		if ((ctl.scan || ctl.shift) && !rem_zero) begin
			ram_re = 1'b1;
		end
		if (ctl.shift) begin
			if (pend_q) begin
				ram_we = 1'b1;
			end else if (rem_zero && up) begin
				// all moves done, drop the new element into the gap
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = elem_q;
			end
		end
	end

	icss_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			elem_q <= element;
			idx_q  <= index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			rem_q   <= '0;
			pend_q  <= 1'b0;
			wa_q    <= '0;
			pos_q   <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.exec) begin
				pos_q  <= tgt_c;
				ptr_q  <= '0;
				rem_q  <= count_q;
				hit_q  <= 1'b0;
				pend_q <= 1'b0;
			end
			if (ctl.scan) begin
				if (!rem_zero) begin
					ptr_q <= ptr_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					wa_q  <= ptr_q;
				end
				pend_q <= !rem_zero;
				if (hit_c) begin
					hit_q <= 1'b1;
					pos_q <= CW'(wa_q);
				end
			end
			if (ctl.prep) begin
				pend_q <= 1'b0;
				if (up) begin
					rem_q <= count_q - pos_q;
					ptr_q <= AW'(count_q - 1'b1);
				end else begin
					rem_q <= count_q - pos_q - 1'b1;
					ptr_q <= AW'(pos_q + 1'b1);
				end
			end
			if (ctl.shift) begin
				if (!rem_zero) begin
					rem_q <= rem_q - 1'b1;
					// read one ahead, the data lands at the neighbor next cycle
					if (up) begin
						ptr_q <= ptr_q - 1'b1;
						wa_q  <= ptr_q + 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						wa_q  <= ptr_q - 1'b1;
					end
				end
				pend_q <= !rem_zero;
			end
			if (ctl.finish) begin
				count_q <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			data_q   <= (cls == OP_READ && !err) ? rdata : '0;
			found_q  <= (cls == OP_FIND) && hit_q;
			length_q <= cnt_new_x[6:0];
			status_q <= st_c;
		end
	end

	assign sts.cls      = cls;
	assign sts.err      = err;
	assign sts.rem_zero = rem_zero;
	assign sts.pend     = pend_q;
	assign sts.hit      = hit_c;

	assign data   = data_q;
	assign found  = found_q;
	assign length = length_q;
	assign status = status_q;

	`ICS_ASSERT_ALWAYS(a_count_bound, count_q <= CAP_C, "element count above capacity")
	`ICS_ASSERT(a_count_at_finish, !ctl.finish |=> count_q == $past(count_q), "count moved outside finish")
	`ICS_ASSERT(a_rem_steps, (ctl.shift && !rem_zero) |=> rem_q == $past(rem_q) - 1'b1, "shift counter skipped")

endmodule

/* sv/icss_ctrl.sv */
// controller state machine of the sequence store, drives the datapath phases
// and both handshakes; needs icss_pkg
`include "indexed_char_sequence_store_top_defines.svh"
module icss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  icss_pkg::sts_t sts,
	output icss_pkg::ctl_t ctl
);
	import icss_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.err) begin
					state_d = S_FINISH;
				end else begin
					case (sts.cls)
						OP_INS, OP_REM: state_d = S_PREP;
						OP_SORT, OP_FIND: state_d = S_SCAN;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.hit || (sts.rem_zero && !sts.pend)) begin
					state_d = (sts.cls == OP_FIND) ? S_FINISH : S_PREP;
				end
			end
			S_PREP: state_d = S_SHIFT;
			S_SHIFT: begin
				if (sts.rem_zero && !sts.pend) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = state_q == S_IDLE;
		ctl.load   = (state_q == S_IDLE) && in_valid;
		ctl.exec   = state_q == S_EXEC;
		ctl.scan   = state_q == S_SCAN;
		ctl.prep   = state_q == S_PREP;
		ctl.shift  = state_q == S_SHIFT;
		ctl.finish = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`ICS_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
	`ICS_ASSERT(a_result_src, $rose(out_valid) |-> $past(state_q == S_FINISH), "result not from finish")
	`ICS_ASSERT(a_finish_next, ctl.finish |=> (out_valid && in_ready), "finish did not post result")

endmodule

/* sv/indexed_char_sequence_store_top.sv */
// top level of the indexed character sequence store
// needs icss_pkg, icss_ctrl, icss_dpath and icss_ram
//
// Ordered store of up to CAPACITY signed characters held in one
// simple dual port RAM, one command item in and one result item out per
// command. Size, clear, read, first, last, replace and every command that
// fails go from the execute state straight to finish. Insert, push, remove
// and pop shift the elements behind the position, find scans the store
// until a match or its end, and sorted insert scans up to the insert point
// and then shifts the rest. The single RAM read port, which moves or
// compares one element per cycle, sets the run time of these commands.
// One command is worked at a time, and the next one is taken while the
// last result waits at the output.
module indexed_char_sequence_store_top #(
	parameter int CAPACITY = icss_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        command,
	input  logic signed [7:0] element,
	input  logic [6:0]        index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] data,
	output logic              found,
	output logic [6:0]        length,
	output logic [1:0]        status
);
	import icss_pkg::*;

	ctl_t ctl;
	sts_t sts;

	icss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	icss_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.command(command),
		.element(element),
		.index  (index),
		.ctl    (ctl),
		.sts    (sts),
		.data   (data),
		.found  (found),
		.length (length),
		.status (status)
	);

endmodule

/* test/indexed_char_sequence_store_top_tb.sv */
// self-checking testbench for indexed_char_sequence_store_top: directed and random command items
// predicts each result with a local mirror of the list and checks it field by field
// depends on icss_pkg and the store rtl only
module indexed_char_sequence_store_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import icss_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic [3:0] CMD_UNUSED_LO = 4'd14;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int MAX_REPORTS = 10;

	typedef enum {BIAS_GROW, BIAS_SHRINK, BIAS_MIX} bias_t;

	typedef struct {
		logic signed [7:0] data;
		logic              found;
		logic [6:0]        length;
		status_t           status;
	} reply_t;

	typedef struct {
		logic [3:0] cmd;
		reply_t     want;
	} awaited_t;

	// mirror of the list contents plus the queue of replies still owed
	class char_list_mirror;
		logic signed [7:0] slots [CAPACITY_DEF];
		int                held = 0;
		awaited_t          pending [$];
		int                errors = 0;

		function void place(int pos, logic signed [7:0] v);
			for (int i = held; i > pos; i--)
				slots[i] = slots[i - 1];
			slots[pos] = v;
			held++;
		endfunction

		function void drop(int pos);
			for (int i = pos; i + 1 < held; i++)
				slots[i] = slots[i + 1];
			held--;
		endfunction

		function void apply_command(logic [3:0] cmd, logic signed [7:0] elem, logic [6:0] idx);
			awaited_t a;
			int pos;
			a.cmd = cmd;
			a.want.data = '0;
			a.want.found = 1'b0;
			a.want.status = ST_OK;
			case (cmd)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (held >= CAPACITY_DEF) a.want.status = ST_FULL;
					else place((cmd == CMD_PUSH_FRONT) ? 0 : held, elem);
				end
				CMD_INSERT_AT: begin
					// range check wins over the full check
					if (int'(idx) > held) a.want.status = ST_RANGE;
					else if (held >= CAPACITY_DEF) a.want.status = ST_FULL;
					else place(int'(idx), elem);
				end
				CMD_INSERT_SORTED: begin
					if (held >= CAPACITY_DEF) begin
						a.want.status = ST_FULL;
					end else begin
						// goes after any equal values
						pos = 0;
						while (pos < held && slots[pos] <= elem)
							pos++;
						place(pos, elem);
					end
				end
				CMD_REMOVE_AT: begin
					if (int'(idx) >= held) a.want.status = ST_RANGE;
					else drop(int'(idx));
				end
				CMD_POP_FRONT, CMD_POP_BACK: begin
					if (held == 0) a.want.status = ST_EMPTY;
					else drop((cmd == CMD_POP_FRONT) ? 0 : held - 1);
				end
				CMD_REPLACE_AT: begin
					if (int'(idx) >= held) a.want.status = ST_RANGE;
					else slots[idx] = elem;
				end
				CMD_READ_AT: begin
					if (int'(idx) >= held) a.want.status = ST_RANGE;
					else a.want.data = slots[idx];
				end
				CMD_FIRST, CMD_LAST: begin
					if (held == 0) a.want.status = ST_EMPTY;
					else a.want.data = slots[(cmd == CMD_FIRST) ? 0 : held - 1];
				end
				CMD_FIND: begin
					for (int i = 0; i < held; i++)
						if (slots[i] == elem)
							a.want.found = 1'b1;
				end
				CMD_CLEAR: held = 0;
				default: ;
			endcase
			a.want.length = held[6:0];
			pending.push_back(a);
		endfunction

		function void check_reply(reply_t got);
			awaited_t a;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with nothing outstanding: data %0d found %0b length %0d status %0d",
						$time, got.data, got.found, got.length, got.status);
				return;
			end
			a = pending.pop_front();
			if (got.data !== a.want.data || got.found !== a.want.found ||
					got.length !== a.want.length || got.status !== a.want.status) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: cmd %0d expected %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
						$time, a.cmd, a.want.data, a.want.found, a.want.length, a.want.status,
						got.data, got.found, got.length, got.status);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [3:0]        command;
	logic signed [7:0] element;
	logic [6:0]        index;
	logic              out_valid;
	logic              out_ready;
	logic signed [7:0] data;
	logic              found;
	logic [6:0]        length;
	logic [1:0]        status;

	char_list_mirror store;
	bit              hold_replies_req = 1'b0;
	int              burst_left = 0;

	indexed_char_sequence_store_top #(
		.CAPACITY(CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.element(element),
		.index(index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data(data),
		.found(found),
		.length(length),
		.status(status)
	);

	always #4 clk = ~clk;

	// offer one item, wait for the handshake, then maybe leave a gap
	task automatic send_command(input logic [3:0] c, input logic signed [7:0] e,
			input logic [6:0] ix);
		int gap;
		int r;
		in_valid <= 1'b1;
		command <= c;
		element <= e;
		index <= ix;
		do @(posedge clk); while (!in_ready);
		store.apply_command(c, e, ix);
		r = $urandom_range(99);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (r < 3) begin
			burst_left = $urandom_range(80, 30);
			gap = 0;
		end else if (r < 65) gap = 0;
		else if (r < 90) gap = $urandom_range(3, 1);
		else if (r < 97) gap = $urandom_range(12, 4);
		else gap = $urandom_range(60, 20);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender goes quiet until every owed result is back
	task automatic wait_all_replies();
		in_valid <= 1'b0;
		do @(posedge clk); while (store.pending.size() != 0);
	endtask

	task automatic pick_command(input bias_t bias, output logic [3:0] c,
			output logic signed [7:0] e, output logic [6:0] ix);
		int r;
		int ins_w;
		int rem_w;
		int hi;
		case (bias)
			BIAS_GROW: begin
				ins_w = 75;
				rem_w = 10;
			end
			BIAS_SHRINK: begin
				ins_w = 10;
				rem_w = 70;
			end
			default: begin
				ins_w = 35;
				rem_w = 30;
			end
		endcase
		r = $urandom_range(99);
		if (r < ins_w) begin
			case ($urandom_range(3))
				0: c = CMD_PUSH_FRONT;
				1: c = CMD_PUSH_BACK;
				2: c = CMD_INSERT_AT;
				default: c = CMD_INSERT_SORTED;
			endcase
		end else if (r < ins_w + rem_w) begin
			case ($urandom_range(2))
				0: c = CMD_REMOVE_AT;
				1: c = CMD_POP_FRONT;
				default: c = CMD_POP_BACK;
			endcase
		end else begin
			r = $urandom_range(99);
			if (r < 4) c = CMD_CLEAR;
			else if (r < 8) c = r[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
			else begin
				case ($urandom_range(5))
					0: c = CMD_REPLACE_AT;
					1: c = CMD_READ_AT;
					2: c = CMD_FIRST;
					3: c = CMD_LAST;
					4: c = CMD_FIND;
					default: c = CMD_SIZE;
				endcase
			end
		end
		// stored values make find hit, a narrow range makes duplicates
		r = $urandom_range(99);
		if (r < 20 && store.held > 0) e = store.slots[$urandom_range(store.held - 1)];
		else if (r < 40) e = 8'(int'($urandom_range(6)) - 3);
		else e = 8'($urandom_range(255));
		hi = (c == CMD_INSERT_AT) ? store.held : store.held - 1;
		if (hi < 0) hi = 0;
		r = $urandom_range(99);
		if (r < 80) ix = 7'($urandom_range(hi));
		else if (r < 90) ix = 7'(hi + 1);
		else ix = 7'($urandom_range(127));
	endtask

	// result side
	initial begin
		int r;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_replies_req) begin
				hold_replies_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(99);
				if (r < 50) begin
					out_ready <= 1'b1;
					repeat ($urandom_range(20, 1)) @(posedge clk);
				end else if (r < 60) begin
					out_ready <= 1'b1;
					repeat ($urandom_range(150, 50)) @(posedge clk);
				end else if (r < 90) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(3, 1)) @(posedge clk);
				end else if (r < 98) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(15, 4)) @(posedge clk);
				end else begin
					out_ready <= 1'b0;
					repeat ($urandom_range(80, 30)) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : watch_replies
		reply_t got;
		if (arst_n && out_valid && out_ready) begin
			got.data = data;
			got.found = found;
			got.length = length;
			got.status = status_t'(status);
			store.check_reply(got);
		end
	end

	initial begin
		#6_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [3:0]        c;
		logic signed [7:0] e;
		logic [6:0]        ix;
		bias_t             bias;
		int                phase_left;
		store = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = '0;
		element = '0;
		index = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store corner cases
		send_command(CMD_SIZE, 0, 0);
		send_command(CMD_POP_FRONT, 0, 0);
		send_command(CMD_POP_BACK, 0, 0);
		send_command(CMD_FIRST, 0, 0);
		send_command(CMD_LAST, 0, 0);
		send_command(CMD_READ_AT, 0, 0);
		send_command(CMD_REMOVE_AT, 0, 0);
		send_command(CMD_REPLACE_AT, 9, 0);
		send_command(CMD_FIND, 0, 0);
		send_command(CMD_INSERT_AT, 1, 1);
		// value extremes, insert at the end, index far out of range
		send_command(CMD_PUSH_FRONT, -128, 0);
		send_command(CMD_PUSH_BACK, 127, 0);
		send_command(CMD_INSERT_AT, 0, 2);
		send_command(CMD_INSERT_AT, 1, 127);
		send_command(CMD_INSERT_SORTED, 5, 0);
		send_command(CMD_INSERT_SORTED, 5, 0);
		send_command(CMD_INSERT_SORTED, -1, 0);
		send_command(CMD_FIND, 5, 0);
		send_command(CMD_FIND, 99, 0);
		send_command(CMD_READ_AT, 0, 0);
		send_command(CMD_FIRST, 0, 0);
		send_command(CMD_LAST, 0, 0);
		send_command(CMD_REPLACE_AT, -7, 1);
		send_command(CMD_REMOVE_AT, 0, 5);
		send_command(CMD_UNUSED_LO, 3, 3);
		send_command(CMD_UNUSED_HI, -3, 64);
		send_command(CMD_CLEAR, 0, 0);
		send_command(CMD_SIZE, 0, 0);
		wait_all_replies();

		bias = BIAS_GROW;
		phase_left = $urandom_range(160, 60);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				// shrink when nearly full, grow when nearly empty
				if (store.held > 48) bias = ($urandom_range(1)) ? BIAS_SHRINK : BIAS_MIX;
				else if (store.held < 16) bias = ($urandom_range(1)) ? BIAS_GROW : BIAS_MIX;
				else bias = bias_t'($urandom_range(2));
				phase_left = $urandom_range(160, 40);
			end
			phase_left--;
			if (n == 300 || n == 620)
				wait_all_replies();
			if (n == 450) begin
				// back up the output and keep offering items
				hold_replies_req = 1'b1;
				burst_left = 30;
			end
			pick_command(bias, c, e, ix);
			send_command(c, e, ix);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (store.pending.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (store.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/icss_pkg.sv
sv/icss_ram.sv
sv/icss_dpath.sv
sv/icss_ctrl.sv
sv/indexed_char_sequence_store_top.sv
test/indexed_char_sequence_store_top_tb.sv
